// ===== hdl/ir_enc_pkg.sv =====
`default_nettype none
package ir_enc_pkg;

    localparam int FRAME_W = 16;
    localparam int PAUSE_W = 8;
    localparam int POS_W   = 5;
    localparam int QDEPTH  = 2;
    localparam int QCNT_W  = 2;

    // symbol index of the stop symbol; start is 0, data bits 1..16
    localparam logic [POS_W-1:0] POS_STOP = 5'd17;
    localparam logic [POS_W-1:0] POS_DATA0 = 5'd16;

    localparam logic [3:0] MODE_PWM    = 4'b0100;
    localparam logic [3:0] MODE_CSTID  = 4'b0110;
    localparam logic [3:0] TOGGLE_MASK = 4'b1000;
    localparam logic [3:0] CHECK_SEED  = 4'hF;

    localparam logic [1:0] REG_LOW_PAUSE   = 2'd0;
    localparam logic [1:0] REG_HIGH_PAUSE  = 2'd1;
    localparam logic [1:0] REG_START_PAUSE = 2'd2;

    localparam logic [PAUSE_W-1:0] LOW_PAUSE_RST   = 8'd16;
    localparam logic [PAUSE_W-1:0] HIGH_PAUSE_RST  = 8'd27;
    localparam logic [PAUSE_W-1:0] START_PAUSE_RST = 8'd45;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_ZERO  = 2'd1,
        SYM_ONE   = 2'd2,
        SYM_STOP  = 2'd3
    } sym_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    typedef struct packed {
        logic [PAUSE_W-1:0] low_pause;
        logic [PAUSE_W-1:0] high_pause;
        logic [PAUSE_W-1:0] start_pause;
    } pause_cfg_t;

    typedef struct packed {
        logic                valid;
        logic [FRAME_W-1:0]  word;
    } frame_xfer_t;

endpackage
`default_nettype wire

// ===== hdl/ir_enc_front.sv =====
`default_nettype none
module ir_enc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      channel,
    input  wire logic                            output_port,
    input  wire logic                            opcode,
    input  wire logic [3:0]                      command,
    output ir_enc_pkg::frame_xfer_t              push,
    input  wire logic                            push_ready
);

    logic       toggle_reg;
    logic       toggle_next;
    logic [3:0] n1;
    logic [3:0] n2;
    logic [3:0] chk;
    logic       take;

    assign in_ready = push_ready;
    assign take     = in_valid && push_ready;

    // toggle flips on every command before the frame is built
    assign toggle_next = ~toggle_reg;

    always_comb
    begin
        n1  = (toggle_next ? ir_enc_pkg::TOGGLE_MASK : 4'b0000) | {2'b00, channel};
        n2  = (opcode ? ir_enc_pkg::MODE_CSTID : ir_enc_pkg::MODE_PWM)
            | {3'b000, output_port};
        chk = ir_enc_pkg::CHECK_SEED ^ n1 ^ n2 ^ command;
        push.valid = in_valid;
        push.word  = {n1, n2, command, chk};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            toggle_reg <= 1'b0;
        end
        else if (take)
        begin
            toggle_reg <= toggle_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ir_enc_queue.sv =====
`default_nettype none
module ir_enc_queue (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ir_enc_pkg::frame_xfer_t               push,
    output logic                                       push_ready,
    output ir_enc_pkg::frame_xfer_t                    head,
    input  wire logic                                  pop
);

    logic [ir_enc_pkg::FRAME_W-1:0] mem_reg [ir_enc_pkg::QDEPTH];
    logic                           wr_ptr_reg;
    logic                           rd_ptr_reg;
    logic [ir_enc_pkg::QCNT_W-1:0]  count_reg;
    logic [ir_enc_pkg::QCNT_W-1:0]  count_next;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = (count_reg != 2'(ir_enc_pkg::QDEPTH));
    assign do_push    = push.valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.word;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(ir_enc_pkg::QDEPTH))
        else $error("frame queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("frame queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== hdl/ir_enc_back.sv =====
`default_nettype none
module ir_enc_back (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ir_enc_pkg::pause_cfg_t               cfg,
    input  wire ir_enc_pkg::frame_xfer_t              head,
    output logic                                      pop,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [1:0]                                symbol_kind,
    output logic [ir_enc_pkg::PAUSE_W-1:0]            pause_cycles,
    output logic [ir_enc_pkg::FRAME_W-1:0]            frame_word,
    output logic                                      last
);

    ir_enc_pkg::back_state_t          state_reg;
    ir_enc_pkg::back_state_t          state_next;
    logic [ir_enc_pkg::FRAME_W-1:0]   frame_reg;
    logic [ir_enc_pkg::POS_W-1:0]     pos_reg;
    logic [ir_enc_pkg::POS_W-1:0]     pos_next;

    logic                             out_valid_reg;
    ir_enc_pkg::sym_t                 kind_reg;
    logic [ir_enc_pkg::PAUSE_W-1:0]   pause_reg;
    logic [ir_enc_pkg::FRAME_W-1:0]   word_reg;
    logic                             last_reg;

    logic                             adv;
    logic                             at_stop;
    logic                             emit;
    logic [3:0]                       bit_idx;
    ir_enc_pkg::sym_t                 sym_kind;
    logic [ir_enc_pkg::PAUSE_W-1:0]   sym_pause;

    assign adv     = !out_valid_reg || out_ready;
    assign at_stop = (pos_reg == ir_enc_pkg::POS_STOP);
    assign emit    = (state_reg == ir_enc_pkg::BK_RUN) && adv;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ir_enc_pkg::BK_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = ir_enc_pkg::BK_RUN;
                end
            end
            ir_enc_pkg::BK_RUN:
            begin
                if (adv && at_stop && !head.valid)
                begin
                    state_next = ir_enc_pkg::BK_IDLE;
                end
            end
            default: state_next = ir_enc_pkg::BK_IDLE;
        endcase
    end

    // outputs: pop and symbol selection
    always_comb
    begin
        pop = 1'b0;
        unique case (state_reg)
            ir_enc_pkg::BK_IDLE: pop = head.valid;
            ir_enc_pkg::BK_RUN:  pop = head.valid && adv && at_stop;
            default:             pop = 1'b0;
        endcase

        // data symbols go out msb first
        bit_idx = 4'(ir_enc_pkg::POS_DATA0 - pos_reg);
        if (pos_reg == '0)
        begin
            sym_kind = ir_enc_pkg::SYM_START;
        end
        else if (at_stop)
        begin
            sym_kind = ir_enc_pkg::SYM_STOP;
        end
        else if (frame_reg[bit_idx])
        begin
            sym_kind = ir_enc_pkg::SYM_ONE;
        end
        else
        begin
            sym_kind = ir_enc_pkg::SYM_ZERO;
        end

        unique case (sym_kind)
            ir_enc_pkg::SYM_ZERO: sym_pause = cfg.low_pause;
            ir_enc_pkg::SYM_ONE:  sym_pause = cfg.high_pause;
            default:              sym_pause = cfg.start_pause;
        endcase

        pos_next = pos_reg;
        if (pop)
        begin
            pos_next = '0;
        end
        else if (emit)
        begin
            pos_next = pos_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ir_enc_pkg::BK_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            if (adv)
            begin
                out_valid_reg <= (state_reg == ir_enc_pkg::BK_RUN);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= head.word;
        end
        if (emit)
        begin
            kind_reg  <= sym_kind;
            pause_reg <= sym_pause;
            word_reg  <= frame_reg;
            last_reg  <= at_stop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign symbol_kind  = kind_reg;
    assign pause_cycles = pause_reg;
    assign frame_word   = word_reg;
    assign last         = last_reg;

    a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> (kind_reg == ir_enc_pkg::SYM_STOP))
        else $error("last flag on a symbol other than stop");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ir_enc_pkg::BK_RUN) |-> (pos_reg <= ir_enc_pkg::POS_STOP))
        else $error("symbol position past stop");

    a_pop_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ir_enc_pkg::BK_IDLE || (at_stop && adv)))
        else $error("new frame loaded mid-frame");

endmodule
`default_nettype wire

// ===== hdl/ir_remote_frame_encoder_unit.sv =====
// channel   | dir | handshake           | payload
// s_axis    | in  | s_tvalid/s_tready   | s_tdata: channel, output_port, command; s_tuser: opcode
// m_axis    | out | m_tvalid/m_tready   | m_tdata: pause_cycles, frame_word; m_tuser: symbol_kind
//           |     |                     | m_tlast: last
// apb       | in  | psel/penable/pready | pause registers at 0x0, 0x4, 0x8
//
// each command yields 18 symbols, one per cycle from the symbol sequencer in the back end
// while m_tready does not stall the output; frames queued back to back follow without a gap.
// a command is taken whenever the two-entry frame queue has room; after acceptance it passes
// through the frame queue and the back-end frame register to the output register.
// reset clears the toggle bit and queue, and loads the pause registers with 16, 27 and 45.
// m_tready low holds the output register and the sequencer; once the queue fills s_tready drops.
`default_nettype none
module ir_remote_frame_encoder_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [1:0] channel, [2] output_port, [6:3] command, [7] zero
    input  wire logic [0:0]  s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] pause_cycles, [23:8] frame_word
    output logic [1:0]       m_tuser,   // [1:0] symbol_kind
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [ir_enc_pkg::PAUSE_W-1:0] low_pause_reg;
    logic [ir_enc_pkg::PAUSE_W-1:0] high_pause_reg;
    logic [ir_enc_pkg::PAUSE_W-1:0] start_pause_reg;
    ir_enc_pkg::pause_cfg_t         cfg;
    logic                           cfg_wr;
    logic [1:0]                     reg_idx;

    ir_enc_pkg::frame_xfer_t        push;
    ir_enc_pkg::frame_xfer_t        head;
    logic                           push_ready;
    logic                           pop;

    logic [1:0]                     symbol_kind;
    logic [ir_enc_pkg::PAUSE_W-1:0] pause_cycles;
    logic [ir_enc_pkg::FRAME_W-1:0] frame_word;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pause_reg   <= ir_enc_pkg::LOW_PAUSE_RST;
            high_pause_reg  <= ir_enc_pkg::HIGH_PAUSE_RST;
            start_pause_reg <= ir_enc_pkg::START_PAUSE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                ir_enc_pkg::REG_LOW_PAUSE:   low_pause_reg   <= pwdata[7:0];
                ir_enc_pkg::REG_HIGH_PAUSE:  high_pause_reg  <= pwdata[7:0];
                ir_enc_pkg::REG_START_PAUSE: start_pause_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ir_enc_pkg::REG_LOW_PAUSE:   prdata = {24'd0, low_pause_reg};
            ir_enc_pkg::REG_HIGH_PAUSE:  prdata = {24'd0, high_pause_reg};
            ir_enc_pkg::REG_START_PAUSE: prdata = {24'd0, start_pause_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg.low_pause   = low_pause_reg;
    assign cfg.high_pause  = high_pause_reg;
    assign cfg.start_pause = start_pause_reg;

    ir_enc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .channel     (s_tdata[1:0]),
        .output_port (s_tdata[2]),
        .opcode      (s_tuser[0]),
        .command     (s_tdata[6:3]),
        .push        (push),
        .push_ready  (push_ready)
    );

    ir_enc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    ir_enc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .head         (head),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .symbol_kind  (symbol_kind),
        .pause_cycles (pause_cycles),
        .frame_word   (frame_word),
        .last         (m_tlast)
    );

    assign m_tdata = {frame_word, pause_cycles};
    assign m_tuser = symbol_kind;

endmodule
`default_nettype wire

// ===== dv/ir_remote_frame_encoder_unit_test.sv =====
`timescale 1ns / 100ps

module ir_remote_frame_encoder_unit_test;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 40;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS = 35;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct {
        ir_enc_pkg::sym_t                   kind;
        logic [ir_enc_pkg::PAUSE_W-1:0]     pause;
        logic [ir_enc_pkg::FRAME_W-1:0]     frame;
        logic                               is_last;
    } pulse_symbol_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // model of the encoder state and pause registers
    logic                           toggle_state = 1'b0;
    logic [ir_enc_pkg::PAUSE_W-1:0] zero_pause = ir_enc_pkg::LOW_PAUSE_RST;
    logic [ir_enc_pkg::PAUSE_W-1:0] one_pause = ir_enc_pkg::HIGH_PAUSE_RST;
    logic [ir_enc_pkg::PAUSE_W-1:0] framing_pause = ir_enc_pkg::START_PAUSE_RST;

    pulse_symbol_t expected_symbols[$];

    int err_count = 0;
    int commands_sent = 0;
    int symbols_checked = 0;
    int settings_used = 0;
    int reads_checked = 0;
    int input_stall_cycles = 0;
    int quiet_cycles = 0;

    // sink and source behavior, set by the tests
    bit src_gaps = 1'b0;
    bit sink_stalls = 1'b0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int stall_left = 0;

    ir_remote_frame_encoder_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [1:0] channel, [2] output_port, [6:3] command, [7] zero
        .s_tuser  (s_tuser),    // [0] opcode
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // [7:0] pause_cycles, [23:8] frame_word
        .m_tuser  (m_tuser),    // [1:0] symbol_kind
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s: got 'h%0h, expected 'h%0h (symbol %0d)",
                     $time, what, got, want, symbols_checked);
    endtask

    function automatic void push_symbol(input ir_enc_pkg::sym_t kind,
                                        input logic [ir_enc_pkg::PAUSE_W-1:0] pause,
                                        input logic [ir_enc_pkg::FRAME_W-1:0] frame,
                                        input logic is_last);
        pulse_symbol_t sym;
        sym.kind = kind;
        sym.pause = pause;
        sym.frame = frame;
        sym.is_last = is_last;
        expected_symbols.push_back(sym);
    endfunction

    // flips the toggle, builds the frame and queues start, 16 data bits msb first, stop
    function automatic void queue_frame_symbols(input logic [1:0] channel, input logic out_sel,
                                                input logic cmd_mode, input logic [3:0] cmd);
        logic [3:0]                     n1;
        logic [3:0]                     n2;
        logic [3:0]                     chk;
        logic [ir_enc_pkg::FRAME_W-1:0] frame;
        toggle_state = ~toggle_state;
        n1 = (toggle_state ? ir_enc_pkg::TOGGLE_MASK : 4'h0) | {2'b00, channel};
        n2 = (cmd_mode ? ir_enc_pkg::MODE_CSTID : ir_enc_pkg::MODE_PWM) | {3'b000, out_sel};
        chk = ir_enc_pkg::CHECK_SEED ^ n1 ^ n2 ^ cmd;
        frame = {n1, n2, cmd, chk};
        push_symbol(ir_enc_pkg::SYM_START, framing_pause, frame, 1'b0);
        for (int i = ir_enc_pkg::FRAME_W - 1; i >= 0; i--)
        begin
            if (frame[i])
                push_symbol(ir_enc_pkg::SYM_ONE, one_pause, frame, 1'b0);
            else
                push_symbol(ir_enc_pkg::SYM_ZERO, zero_pause, frame, 1'b0);
        end
        push_symbol(ir_enc_pkg::SYM_STOP, framing_pause, frame, 1'b1);
    endfunction

    function automatic logic [ir_enc_pkg::PAUSE_W-1:0] pick_pause();
        case ($urandom_range(0, 3))
            0: return 8'd1;
            1: return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ir_enc_pkg::REG_LOW_PAUSE:   zero_pause = value[ir_enc_pkg::PAUSE_W-1:0];
            ir_enc_pkg::REG_HIGH_PAUSE:  one_pause = value[ir_enc_pkg::PAUSE_W-1:0];
            ir_enc_pkg::REG_START_PAUSE: framing_pause = value[ir_enc_pkg::PAUSE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        logic [ir_enc_pkg::PAUSE_W-1:0] want;
        for (int r = 0; r < 3; r++)
        begin
            case (2'(r))
                ir_enc_pkg::REG_LOW_PAUSE:  want = zero_pause;
                ir_enc_pkg::REG_HIGH_PAUSE: want = one_pause;
                default:                    want = framing_pause;
            endcase
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {2'(r), 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            psel <= 1'b0;
            penable <= 1'b0;
            reads_checked++;
            if (prdata !== {24'h0, want})
                report_mismatch("register readback", prdata, {24'h0, want});
        end
    endtask

    task automatic send_command(input logic [1:0] channel, input logic out_sel,
                                input logic cmd_mode, input logic [3:0] cmd);
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, cmd, out_sel, channel};
        s_tuser <= cmd_mode;
        do @(posedge clk); while (!s_tready);
        queue_frame_symbols(channel, out_sel, cmd_mode, cmd);
        commands_sent++;
    endtask

    task automatic source_gap();
        int n;
        if (!src_gaps)
            return;
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(8, 40);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_random_commands(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_command(2'($urandom), 1'($urandom), 1'($urandom), 4'($urandom));
            source_gap();
        end
    endtask

    // every command yields symbols, so an empty queue means the encoder is idle
    task automatic wait_for_symbols();
        s_tvalid <= 1'b0;
        while (expected_symbols.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_reset_values();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        settings_used++;
        check_registers();
        send_command(2'd0, 1'b0, 1'b0, 4'h0);
        send_command(2'd3, 1'b1, 1'b1, 4'hF);
        send_command(2'd1, 1'b0, 1'b1, 4'hA);
        send_command(2'd2, 1'b1, 1'b0, 4'h5);
        send_command(2'd0, 1'b1, 1'b0, 4'hF);
        send_command(2'd3, 1'b0, 1'b1, 4'h0);
        wait_for_symbols();
    endtask

    task automatic test_zero_pause();
        settings_used++;
        apb_write(ir_enc_pkg::REG_LOW_PAUSE, 32'h0);
        apb_write(ir_enc_pkg::REG_HIGH_PAUSE, 32'h0);
        apb_write(ir_enc_pkg::REG_START_PAUSE, 32'h0);
        check_registers();
        send_command(2'd1, 1'b1, 1'b1, 4'h9);
        send_command(2'd2, 1'b0, 1'b0, 4'h6);
        send_command(2'd3, 1'b1, 1'b0, 4'h3);
        wait_for_symbols();
    endtask

    task automatic test_register_limits();
        // upper bits of the write data are dropped
        settings_used++;
        apb_write(ir_enc_pkg::REG_LOW_PAUSE, 32'h1234_5601);
        apb_write(ir_enc_pkg::REG_HIGH_PAUSE, 32'hFFFF_FFFF);
        apb_write(ir_enc_pkg::REG_START_PAUSE, 32'hABCD_EF80);
        check_registers();
        send_command(2'd0, 1'b1, 1'b1, 4'hC);
        send_command(2'd2, 1'b0, 1'b1, 4'h1);
        send_command(2'd1, 1'b1, 1'b0, 4'hE);
        wait_for_symbols();
        // write to the unused slot must leave all registers alone
        settings_used++;
        apb_write(ir_enc_pkg::REG_LOW_PAUSE, 32'h0000_00FF);
        apb_write(ir_enc_pkg::REG_HIGH_PAUSE, 32'h0000_0001);
        apb_write(ir_enc_pkg::REG_START_PAUSE, 32'h0000_0001);
        apb_write(REG_UNUSED, 32'h5A5A_5A5A);
        check_registers();
        send_command(2'd3, 1'b0, 1'b0, 4'h7);
        send_command(2'd0, 1'b0, 1'b1, 4'h8);
        send_command(2'd2, 1'b1, 1'b1, 4'hB);
        wait_for_symbols();
    endtask

    task automatic test_backpressure();
        settings_used++;
        apb_write(ir_enc_pkg::REG_LOW_PAUSE, {24'($urandom), pick_pause()});
        apb_write(ir_enc_pkg::REG_HIGH_PAUSE, {24'($urandom), pick_pause()});
        apb_write(ir_enc_pkg::REG_START_PAUSE, {24'($urandom), pick_pause()});
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_requests++;
        send_random_commands(10);
        wait_for_symbols();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settings_used++;
            apb_write(ir_enc_pkg::REG_START_PAUSE, {24'($urandom), pick_pause()});
            apb_write(ir_enc_pkg::REG_LOW_PAUSE, {24'($urandom), pick_pause()});
            apb_write(ir_enc_pkg::REG_HIGH_PAUSE, {24'($urandom), pick_pause()});
            if ($urandom_range(0, 3) == 0)
                apb_write(REG_UNUSED, $urandom);
            src_gaps = (p != 2);
            sink_stalls = (p != 1);
            send_random_commands(PHASE_ITEMS);
            wait_for_symbols();
        end
    endtask

    // sink side: random short and long stalls, plus one long hold on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                         : $urandom_range(10, 30);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pulse_symbol_t want;
        if (rst_n)
        begin
            if (s_tvalid && !s_tready)
                input_stall_cycles++;
            if (m_tvalid && m_tready)
            begin
                if (expected_symbols.size() == 0)
                    report_mismatch("symbol with nothing expected", {8'h0, m_tdata}, 32'h0);
                else
                begin
                    want = expected_symbols.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch("symbol_kind", 32'(m_tuser), 32'(want.kind));
                    if (m_tdata[7:0] !== want.pause)
                        report_mismatch("pause_cycles", 32'(m_tdata[7:0]), 32'(want.pause));
                    if (m_tdata[23:8] !== want.frame)
                        report_mismatch("frame_word", 32'(m_tdata[23:8]), 32'(want.frame));
                    if (m_tlast !== want.is_last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
                    symbols_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d symbols outstanding",
                     quiet_cycles, expected_symbols.size());
            $display("ir_remote_frame_encoder_unit test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_zero_pause();
        test_register_limits();
        test_backpressure();
        test_random_traffic();
        repeat (20) @(posedge clk);
        if (expected_symbols.size() != 0)
            report_mismatch("symbols never received", 32'(expected_symbols.size()), 32'd0);
        $display("ran %0d commands, %0d symbols checked over %0d pause settings",
                 commands_sent, symbols_checked, settings_used);
        $display("%0d register reads checked, input held off for %0d cycles",
                 reads_checked, input_stall_cycles);
        if (err_count == 0)
            $display("ir_remote_frame_encoder_unit test passed");
        else
            $display("ir_remote_frame_encoder_unit test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ir_enc_pkg.sv
hdl/ir_enc_front.sv
hdl/ir_enc_queue.sv
hdl/ir_enc_back.sv
hdl/ir_remote_frame_encoder_unit.sv
dv/ir_remote_frame_encoder_unit_test.sv
